[rtl/core/ndt_pkg.sv]
// Shared types and constants for the NAND block disturb tracker.
// No dependencies; imported by ndt_ctrl and the tracker top level.
package ndt_pkg;

  localparam int PageW  = 24;
  localparam int CountW = 32;
  localparam int CfgW   = 32;

  // configuration register indexes
  localparam logic [1:0] REG_BLOCK_SHIFT = 2'd0;
  localparam logic [1:0] REG_READ_LIMIT  = 2'd1;
  localparam logic [1:0] REG_ERASE_LIMIT = 2'd2;

  // operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_ERASE = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_READ_LIMIT  = 2'd1;
  localparam logic [1:0] STAT_ERASE_LIMIT = 2'd2;
  localparam logic [1:0] STAT_OUT_RANGE   = 2'd3;

  localparam logic [3:0]        RST_BLOCK_SHIFT = 4'd6;
  localparam logic [CountW-1:0] RST_READ_LIMIT  = 32'd100000;
  localparam logic [CountW-1:0] RST_ERASE_LIMIT = 32'd3000;

  typedef struct packed {
    logic             operation;
    logic [PageW-1:0] page;
  } ndt_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PageW-1:0]  block_index;
    logic [CountW-1:0] new_count;
  } ndt_out_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } ndt_state_t;

  // control strobes from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic upd_en;
    logic clr_en;
  } ndt_ctl_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == {CountW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/core/ndt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ndt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ndt_ctrl.sv]
// Sequencer: post-reset clearing sweep and per-beat read/update interlock.
// Depends on ndt_pkg.
module ndt_ctrl
  import ndt_pkg::*;
#(
  parameter int BLOCK_COUNT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           out_busy,
  output ndt_ctl_t                       ctl,
  output logic [$clog2(BLOCK_COUNT)-1:0] clr_addr
);

  localparam int AW = $clog2(BLOCK_COUNT);
  localparam logic [AW-1:0] LastAddr = AW'(BLOCK_COUNT - 1);

  ndt_state_t    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    ctl         = '0;
    case (state_r)
      S_CLEAR: begin
        ctl.clr_en  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LastAddr) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid) begin
          ctl.rd_en = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // RAM data is held; wait for a free output slot
        if (!out_busy) begin
          ctl.upd_en = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign clr_addr = clr_cnt_r;

endmodule

[rtl/core/nand_block_disturb_tracker_unit.sv]
// NAND block read-disturb and erase-wear tracker, top level.
// Depends on ndt_pkg, ndt_ram and ndt_ctrl.
//
// After reset the block sweeps both count RAMs to zero, one entry per cycle,
// and takes no input beat meanwhile (config writes are taken). Each beat then
// reads the block's counts from the RAMs (registered read), then updates the
// counts, writes them back and loads the output register, waiting while that
// register still holds an untaken result. The output register lets the next
// beat be taken while a result waits. Block index is page >> block_shift;
// indexes at or above BLOCK_COUNT report status 3, count 0, and store nothing.
module nand_block_disturb_tracker_unit
  import ndt_pkg::*;
#(
  parameter int BLOCK_COUNT = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ndt_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ndt_out_t        out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_wdata
);

  localparam int AW = $clog2(BLOCK_COUNT);

  logic [3:0]        block_shift_r;
  logic [CountW-1:0] read_limit_r;
  logic [CountW-1:0] erase_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r <= RST_BLOCK_SHIFT;
      read_limit_r  <= RST_READ_LIMIT;
      erase_limit_r <= RST_ERASE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SHIFT: block_shift_r <= cfg_wdata[3:0];
        REG_READ_LIMIT:  read_limit_r  <= cfg_wdata[CountW-1:0];
        REG_ERASE_LIMIT: erase_limit_r <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  ndt_ctl_t      ctl;
  logic [AW-1:0] clr_addr;
  logic          out_valid_r;
  ndt_out_t      out_data_r;
  logic          out_busy;

  assign out_busy = out_valid_r && !out_ready;

  ndt_ctrl #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  assign in_ready = ctl.in_ready;

  // beat capture
  logic [PageW-1:0] blk_in;
  logic             oor_in;
  logic             op_r;
  logic [PageW-1:0] blk_r;
  logic             oor_r;

  assign blk_in = in_data.page >> block_shift_r;
  assign oor_in = blk_in >= PageW'(BLOCK_COUNT);

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      op_r  <= in_data.operation;
      blk_r <= blk_in;
      oor_r <= oor_in;
    end
  end

  // count RAMs
  logic              rc_we, ec_we;
  logic [AW-1:0]     waddr;
  logic [CountW-1:0] rc_wdata, ec_wdata;
  logic [CountW-1:0] rc_rdata, ec_rdata;

  ndt_ram #(
    .WIDTH(CountW),
    .DEPTH(BLOCK_COUNT)
  ) u_read_ram (
    .clk   (clk),
    .we    (rc_we),
    .waddr (waddr),
    .wdata (rc_wdata),
    .re    (ctl.rd_en),
    .raddr (blk_in[AW-1:0]),
    .rdata (rc_rdata)
  );

  ndt_ram #(
    .WIDTH(CountW),
    .DEPTH(BLOCK_COUNT)
  ) u_erase_ram (
    .clk   (clk),
    .we    (ec_we),
    .waddr (waddr),
    .wdata (ec_wdata),
    .re    (ctl.rd_en),
    .raddr (blk_in[AW-1:0]),
    .rdata (ec_rdata)
  );

  // update
  logic [CountW-1:0] rc_inc, ec_inc;
  ndt_out_t          res;

  assign rc_inc = sat_inc(rc_rdata);
  assign ec_inc = sat_inc(ec_rdata);

  always_comb begin
    res.block_index = blk_r;
    res.new_count   = '0;
    res.status      = STAT_OK;
    rc_we    = 1'b0;
    ec_we    = 1'b0;
    rc_wdata = '0;
    ec_wdata = ec_inc;
    waddr    = blk_r[AW-1:0];
    if (ctl.clr_en) begin
      rc_we    = 1'b1;
      ec_we    = 1'b1;
      ec_wdata = '0;
      waddr    = clr_addr;
    end else if (oor_r) begin
      res.status = STAT_OUT_RANGE;
    end else if (op_r == OP_READ) begin
      rc_we         = ctl.upd_en;
      rc_wdata      = rc_inc;
      res.new_count = rc_inc;
      if (rc_inc > read_limit_r) begin
        res.status = STAT_READ_LIMIT;
      end
    end else begin
      // erase also resets the read count
      rc_we         = ctl.upd_en;
      ec_we         = ctl.upd_en;
      res.new_count = ec_inc;
      if (ec_inc > erase_limit_r) begin
        res.status = STAT_ERASE_LIMIT;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.upd_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("beat accepted while previous beat in flight");

  a_oor_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.upd_en && oor_r) |-> (!rc_we && !ec_we))
    else $error("out-of-range beat wrote a count RAM");

  a_erase_clears_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.upd_en && !oor_r && op_r == OP_ERASE) |-> (rc_we && rc_wdata == '0))
    else $error("erase did not clear read count");

  a_update_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.upd_en |=> (out_valid && out_data.block_index == $past(blk_r)))
    else $error("update did not present result");
`endif

endmodule

[test/nand_block_disturb_tracker_unit_test.sv]
// Self-checking bench for nand_block_disturb_tracker_unit: random page reads and
// erases against a behavioral count tracker, with random stalls on both channels.
// Depends on ndt_pkg and the tracker RTL.
`timescale 1ns / 100ps

module nand_block_disturb_tracker_unit_test;
  import ndt_pkg::*;

  localparam int BLOCK_COUNT  = 1024;
  localparam int AW           = $clog2(BLOCK_COUNT);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 155;
  localparam int RAND_PHASES  = 8;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  ndt_in_t         in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ndt_out_t        out_data;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = REG_BLOCK_SHIFT;
  logic [CfgW-1:0] cfg_wdata = '0;

  nand_block_disturb_tracker_unit #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block's registers and count stores
  logic [3:0]        shift_cfg = RST_BLOCK_SHIFT;
  logic [CountW-1:0] read_lim  = RST_READ_LIMIT;
  logic [CountW-1:0] erase_lim = RST_ERASE_LIMIT;
  bit   [CountW-1:0] read_cnt  [BLOCK_COUNT];
  bit   [CountW-1:0] erase_cnt [BLOCK_COUNT];

  ndt_in_t  access_q[$];
  ndt_out_t pending_reports[$];
  int       accesses_queued = 0;
  int       accesses_taken = 0;
  int       cycle_count = 0;
  int       errors = 0;
  logic     in_fire = 1'b0;

  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_asked = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_FLOW;

  function automatic logic [CountW-1:0] count_up_sat(input logic [CountW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic ndt_out_t track_access(input ndt_in_t acc);
    ndt_out_t         res;
    logic [PageW-1:0] blk;
    logic [AW-1:0]    bi;
    blk = acc.page >> shift_cfg;
    bi = blk[AW-1:0];
    res.block_index = blk;
    res.status = STAT_OK;
    res.new_count = '0;
    if (blk >= PageW'(BLOCK_COUNT)) begin
      res.status = STAT_OUT_RANGE;
    end else if (acc.operation == OP_READ) begin
      read_cnt[bi] = count_up_sat(read_cnt[bi]);
      res.new_count = read_cnt[bi];
      if (res.new_count > read_lim) res.status = STAT_READ_LIMIT;
    end else begin
      erase_cnt[bi] = count_up_sat(erase_cnt[bi]);
      read_cnt[bi] = '0;
      res.new_count = erase_cnt[bi];
      if (res.new_count > erase_lim) res.status = STAT_ERASE_LIMIT;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [CountW-1:0] exp_v,
                                 input logic [CountW-1:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
  endtask

  task automatic check_report(input ndt_out_t act);
    ndt_out_t exp_r;
    if (pending_reports.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, expected none, got %h", $time, act);
    end else begin
      exp_r = pending_reports.pop_front();
      if (act.status !== exp_r.status)
        report_mismatch("status", CountW'(exp_r.status), CountW'(act.status));
      if (act.block_index !== exp_r.block_index)
        report_mismatch("block_index", CountW'(exp_r.block_index),
                        CountW'(act.block_index));
      if (act.new_count !== exp_r.new_count)
        report_mismatch("new_count", exp_r.new_count, act.new_count);
    end
  endtask

  // monitor: input acceptance feeds the tracker, result beats are checked
  always @(posedge clk) begin
    cycle_count++;
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      pending_reports.push_back(track_access(in_data));
      accesses_taken++;
    end
    if (rst_n && out_valid && out_ready) check_report(out_data);
  end

  // driver: bursts of beats separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        in_data <= access_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall patterns plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FLOW:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 9) != 0);
        default:   out_ready <= ((cycle_count % 5) < 2);
      endcase
    end
  end

  task automatic queue_access(input logic op, input logic [PageW-1:0] page);
    ndt_in_t a;
    a.operation = op;
    a.page = page;
    access_q.push_back(a);
    accesses_queued++;
  endtask

  task automatic wait_idle();
    while (accesses_taken != accesses_queued || pending_reports.size() != 0)
      @(negedge clk);
  endtask

  // only called with the block idle, so the shadow can change right away
  task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BLOCK_SHIFT: shift_cfg = val[3:0];
      REG_READ_LIMIT:  read_lim = val;
      REG_ERASE_LIMIT: erase_lim = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [3:0] shift, input logic [CountW-1:0] rlim,
                           input logic [CountW-1:0] elim);
    // junk in the upper bits of the shift write must be ignored
    write_reg(REG_BLOCK_SHIFT, {(CfgW - 4)'($urandom()), shift});
    write_reg(REG_READ_LIMIT, rlim);
    write_reg(REG_ERASE_LIMIT, elim);
  endtask

  function automatic logic [PageW-1:0] page_in_block(input int blk);
    logic [47:0] wide;
    wide = (48'(blk) << shift_cfg) | 48'($urandom & ((1 << shift_cfg) - 1));
    return wide[PageW-1:0];
  endfunction

  function automatic logic [CountW-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:         return '0;
      1:         return '1;
      2, 3, 4, 5: return $urandom_range(1, 12);
      6:         return $urandom_range(13, 40);
      default:   return $urandom;
    endcase
  endfunction

  // often hits a few hot blocks so the limits get crossed
  task automatic queue_random(input int hot_base, input int top_blk);
    int   r;
    logic op;
    r = $urandom_range(0, 99);
    op = ($urandom_range(0, 99) < 20) ? OP_ERASE : OP_READ;
    if (r < 45)
      queue_access(op, page_in_block(hot_base + $urandom_range(0, 3)));
    else if (r < 80)
      queue_access(op, page_in_block($urandom_range(0, top_blk)));
    else if (r < 90)
      queue_access(op, page_in_block($urandom_range(BLOCK_COUNT - 2, BLOCK_COUNT + 40)));
    else
      queue_access(op, PageW'($urandom));
  endtask

  initial begin
    logic [3:0] shift;
    int         top_blk;
    int         hot_base;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: shift 6, so block 1023 ends at page 65535
    queue_access(OP_READ, 24'd0);
    queue_access(OP_READ, 24'd63);
    queue_access(OP_READ, 24'd64);
    queue_access(OP_ERASE, 24'd5);
    queue_access(OP_READ, 24'd0);
    queue_access(OP_READ, 24'd65535);
    queue_access(OP_READ, 24'd65536);
    queue_access(OP_ERASE, 24'hFFFFFF);
    queue_access(OP_READ, 24'hAAAAAA);
    queue_access(OP_ERASE, 24'h555555);
    wait_idle();

    // zero limits: every in-range access is over its limit
    write_all(4'd0, '0, '0);
    queue_access(OP_READ, 24'd1023);
    queue_access(OP_READ, 24'd1024);
    queue_access(OP_ERASE, 24'd0);
    queue_access(OP_ERASE, 24'd1023);
    queue_access(OP_READ, 24'd1023);
    wait_idle();

    // shift 15 keeps every page in range; an all-ones read limit never trips
    write_all(4'd15, '1, 32'd1);
    queue_access(OP_READ, 24'hFFFFFF);
    queue_access(OP_ERASE, 24'hFFFFFF);
    queue_access(OP_ERASE, 24'hFFFFFF);
    queue_access(OP_READ, 24'hFFFFFF);
    queue_access(OP_READ, 24'd0);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       shift = 4'd0;
        1:       shift = 4'd15;
        2:       shift = 4'd12;
        3:       shift = 4'd6;
        default: shift = $urandom_range(0, 15);
      endcase
      write_all(shift, pick_limit(), pick_limit());
      top_blk = ((1 << PageW) - 1) >> shift;
      if (top_blk > BLOCK_COUNT - 1) top_blk = BLOCK_COUNT - 1;
      hot_base = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, top_blk - 3);
      // one phase runs against a long receiver hold-off so the input backs up
      if (p == 3) hold_asked++;
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random(hot_base, top_blk);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected 0 outstanding, got %0d", $time,
               pending_reports.size(), pending_reports.size());
    end
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

endmodule
